// ===== rtl/sptq_pkg.sv =====
// shared types and codes for the sorted priority task queue
package sptq_pkg;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_POP    = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_LIST   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_LIST = 1'b1
   } state_type;

   localparam int unsigned ID_W   = 16;
   localparam int unsigned PRIO_W = 8;

   typedef struct packed {
      action_type          action;
      logic [ID_W-1:0]     task_id;
      logic [PRIO_W-1:0]   task_priority;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [ID_W-1:0]     out_id;
      logic [PRIO_W-1:0]   out_priority;
      logic                last;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic insert;
      logic pop;
      logic remove;
      logic list_empty;
      logic list_begin;
      logic list_step;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic empty;
      logic list_done;
   } stat_type;

endpackage

// ===== rtl/sorted_priority_task_queue_core.sv =====
// Sorted priority task queue: QUEUE_DEPTH (id, priority) entries kept in
// descending priority order in a row of registered cells. An action is
// taken when start is high and busy is low. Insert, pop and remove-by-id
// finish in the cycle they are taken: all cells compare against the
// request at once and shift in one step, so one such action can be taken
// every cycle and its single result appears on rsp_valid/rsp_data in the
// next cycle. A list action on a non-empty queue raises busy while the
// cells rotate past the head, one result per cycle, the final one flagged
// by last; a list of an empty queue gives one result with empty status.
// Results are strobed for one cycle and cannot be held off.
module sorted_priority_task_queue_core #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  sptq_pkg::req_type  req_data,
   output logic               rsp_valid,
   output sptq_pkg::rsp_type  rsp_data
);

   sptq_pkg::cmd_type  cmd;
   sptq_pkg::stat_type stat;

   sptq_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_data.action),
      .stat   (stat),
      .busy   (busy),
      .cmd    (cmd)
   );

   sptq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

// ===== rtl/sptq_ctrl.sv =====
// controller state machine: decodes actions and sequences the list walk
module sptq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sptq_pkg::action_type  action,
   input  sptq_pkg::stat_type    stat,
   output logic                  busy,
   output sptq_pkg::cmd_type     cmd
);

   sptq_pkg::state_type state_ff;
   sptq_pkg::state_type state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sptq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff == sptq_pkg::S_LIST);
      accept   = start && (state_ff == sptq_pkg::S_IDLE);
      case (state_ff)
         sptq_pkg::S_IDLE: begin
            if (accept) begin
               case (action)
                  sptq_pkg::ACT_INSERT: cmd.insert = 1'b1;
                  sptq_pkg::ACT_POP:    cmd.pop    = 1'b1;
                  sptq_pkg::ACT_REMOVE: cmd.remove = 1'b1;
                  sptq_pkg::ACT_LIST: begin
                     if (stat.empty) begin
                        cmd.list_empty = 1'b1;
                     end else begin
                        cmd.list_begin = 1'b1;
                        state_in       = sptq_pkg::S_LIST;
                     end
                  end
                  default: cmd = '0;
               endcase
            end
         end
         sptq_pkg::S_LIST: begin
            cmd.list_step = 1'b1;
            if (stat.list_done) begin
               state_in = sptq_pkg::S_IDLE;
            end
         end
         default: state_in = sptq_pkg::S_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_list_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.list_step |-> busy)
      else $error("list step outside list walk");
   a_begin_enters_list: assert property (@(posedge clock) disable iff (reset)
      cmd.list_begin |=> state_ff == sptq_pkg::S_LIST)
      else $error("list begin did not enter list walk");
   a_no_accept_in_list: assert property (@(posedge clock) disable iff (reset)
      busy |-> !(cmd.insert || cmd.pop || cmd.remove || cmd.list_begin))
      else $error("command issued during list walk");
`endif

endmodule

// ===== rtl/sptq_datapath.sv =====
// sorted entry array, fill count, list index and result register
module sptq_datapath #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  sptq_pkg::req_type   req,
   input  sptq_pkg::cmd_type   cmd,
   output sptq_pkg::stat_type  stat,
   output logic                rsp_valid,
   output sptq_pkg::rsp_type   rsp
);

   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned IW = $clog2(QUEUE_DEPTH);

   logic [sptq_pkg::ID_W-1:0]   ids_ff   [QUEUE_DEPTH];
   logic [sptq_pkg::ID_W-1:0]   ids_in   [QUEUE_DEPTH];
   logic [sptq_pkg::PRIO_W-1:0] prios_ff [QUEUE_DEPTH];
   logic [sptq_pkg::PRIO_W-1:0] prios_in [QUEUE_DEPTH];
   logic [sptq_pkg::ID_W-1:0]   up_id    [QUEUE_DEPTH];
   logic [sptq_pkg::PRIO_W-1:0] up_prio  [QUEUE_DEPTH];
   logic [sptq_pkg::ID_W-1:0]   dn_id    [QUEUE_DEPTH];
   logic [sptq_pkg::PRIO_W-1:0] dn_prio  [QUEUE_DEPTH];

   logic [CW-1:0]          count_ff, count_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sptq_pkg::rsp_type      rsp_ff, rsp_in;

   logic [QUEUE_DEPTH-1:0] live, gt, prev_gt, match, hit, rm_mask, wrap;
   logic                   found, empty, full, list_done;
   logic [sptq_pkg::PRIO_W-1:0] hit_prio;

   // neighbor taps of each cell
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_tap
      if (g == QUEUE_DEPTH - 1) begin : g_top
         assign up_id[g]   = ids_ff[0];
         assign up_prio[g] = prios_ff[0];
      end else begin : g_mid
         assign up_id[g]   = ids_ff[g+1];
         assign up_prio[g] = prios_ff[g+1];
      end
      if (g == 0) begin : g_head
         assign dn_id[g]   = req.task_id;
         assign dn_prio[g] = req.task_priority;
         assign prev_gt[g] = 1'b1;
      end else begin : g_body
         assign dn_id[g]   = ids_ff[g-1];
         assign dn_prio[g] = prios_ff[g-1];
         assign prev_gt[g] = gt[g-1];
      end
      assign live[g]  = CW'(g) < count_ff;
      assign gt[g]    = live[g] && (prios_ff[g] > req.task_priority);
      assign match[g] = live[g] && (ids_ff[g] == req.task_id);
      assign wrap[g]  = CW'(g) == (count_ff - CW'(1));
   end

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign list_done = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign found     = |match;
   // first match from the head, and every cell from there on shifts up
   assign hit       = match & (~match + QUEUE_DEPTH'(1));
   assign rm_mask   = ~(hit - QUEUE_DEPTH'(1));

   assign stat.empty     = empty;
   assign stat.list_done = list_done;

   always_comb begin
      hit_prio = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_prio = hit_prio | (prios_ff[i] & {sptq_pkg::PRIO_W{hit[i]}});
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ids_in[i]   = ids_ff[i];
         prios_in[i] = prios_ff[i];
         if (cmd.insert && !full && !gt[i]) begin
            if (prev_gt[i]) begin
               ids_in[i]   = req.task_id;
               prios_in[i] = req.task_priority;
            end else begin
               ids_in[i]   = dn_id[i];
               prios_in[i] = dn_prio[i];
            end
         end else if ((cmd.pop && !empty) || (cmd.remove && found && rm_mask[i])) begin
            ids_in[i]   = up_id[i];
            prios_in[i] = up_prio[i];
         end else if (cmd.list_step) begin
            // rotate the live entries by one so the head walks the list
            if (wrap[i]) begin
               ids_in[i]   = ids_ff[0];
               prios_in[i] = prios_ff[0];
            end else begin
               ids_in[i]   = up_id[i];
               prios_in[i] = up_prio[i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert && !full) begin
         count_in = count_ff + CW'(1);
      end else if ((cmd.pop && !empty) || (cmd.remove && found)) begin
         count_in = count_ff - CW'(1);
      end

      idx_in = idx_ff;
      if (cmd.list_begin) begin
         idx_in = '0;
      end else if (cmd.list_step) begin
         idx_in = idx_ff + IW'(1);
      end

      rsp_valid_in = cmd.insert || cmd.pop || cmd.remove || cmd.list_empty || cmd.list_step;
      rsp_in        = '0;
      rsp_in.status = sptq_pkg::ST_OK;
      rsp_in.last   = 1'b1;
      if (cmd.insert) begin
         if (full) begin
            rsp_in.status = sptq_pkg::ST_FULL;
         end
      end else if (cmd.pop) begin
         if (empty) begin
            rsp_in.status = sptq_pkg::ST_EMPTY;
         end else begin
            rsp_in.out_id       = ids_ff[0];
            rsp_in.out_priority = prios_ff[0];
         end
      end else if (cmd.remove) begin
         if (empty) begin
            rsp_in.status = sptq_pkg::ST_EMPTY;
         end else if (found) begin
            rsp_in.out_id       = req.task_id;
            rsp_in.out_priority = hit_prio;
         end else begin
            rsp_in.status = sptq_pkg::ST_NOTFOUND;
         end
      end else if (cmd.list_empty) begin
         rsp_in.status = sptq_pkg::ST_EMPTY;
      end else if (cmd.list_step) begin
         rsp_in.out_id       = ids_ff[0];
         rsp_in.out_priority = prios_ff[0];
         rsp_in.last         = list_done;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ids_ff[i]   <= ids_in[i];
         prios_ff[i] <= prios_in[i];
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond depth");
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      cmd.insert && full |=> rsp_valid_ff && rsp_ff.status == sptq_pkg::ST_FULL
         && $stable(count_ff))
      else $error("insert into full queue not rejected");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop && !empty |=> count_ff == $past(count_ff) - CW'(1))
      else $error("pop did not shrink the queue");
   a_list_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.list_step |=> $stable(count_ff) && rsp_valid_ff)
      else $error("list step disturbed the count or lost a transfer");
`endif

endmodule
